>>> hw/rtl/two_choice_hash_bucket_balancer_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-choice hash bucket balancer
// Clocked assertion helpers used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef TWO_CHOICE_HASH_BUCKET_BALANCER_TOP_MACROS_SVH
`define TWO_CHOICE_HASH_BUCKET_BALANCER_TOP_MACROS_SVH

// Property checked on every rising clock edge, disabled while reset is held.
`define TCHB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Property checked on every rising clock edge, reset included.
`define TCHB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hw/rtl/tchb_pkg.sv
// ----------------------------------------------------------------------------
// tchb_pkg
// Shared constants, codes and control types of the bucket balancer.
// ----------------------------------------------------------------------------
package tchb_pkg;

  // Table geometry and counter width.
  localparam int unsigned MAX_HALF_BUCKETS = 512;
  localparam int unsigned NUM_BUCKETS      = 2 * MAX_HALF_BUCKETS;
  localparam int unsigned IDX_W            = $clog2(NUM_BUCKETS);
  localparam int unsigned TOT_W            = IDX_W + 1;
  localparam int unsigned COUNT_WIDTH      = 16;

  // Field widths.
  localparam int unsigned KEY_W  = 31;
  localparam int unsigned HALF_W = 10;
  localparam int unsigned LEN_W  = 16;

  // Hash moduli.
  localparam int unsigned HASH_A = 109;
  localparam int unsigned HASH_B = 137;

  // Key reduction: one hex digit per step, most significant digit first.
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned DIGITS     = (KEY_W + NIB_W - 1) / NIB_W;
  localparam int unsigned PAD_W      = DIGITS * NIB_W;
  localparam int unsigned DIG_W      = $clog2(DIGITS);
  localparam int unsigned REM_W      = $clog2(HASH_B);
  localparam int          HALF_STEPS = REM_W / 2;

  // Stream widths, rounded up to whole bytes.
  localparam int unsigned IN_TDATA_W  = ((KEY_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((IDX_W + LEN_W + 7) / 8) * 8;

  // Mode carried in the input tuser.
  localparam logic MODE_REPORT = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_BUCKET_COUNT = 2'd0,
    CFG_TARGET_KEY        = 2'd1
  } cfg_idx_e;

  // Program steps, in program order.
  typedef enum logic [3:0] {
    S_CLEAR   = 4'd0,
    S_IDLE    = 4'd1,
    S_DIGIT   = 4'd2,
    S_RED_HI  = 4'd3,
    S_RED_LO  = 4'd4,
    S_RD_H1   = 4'd5,
    S_RD_H2   = 4'd6,
    S_CAP_B   = 4'd7,
    S_INS_WR  = 4'd8,
    S_RPT_RD  = 4'd9,
    S_RPT_CAP = 4'd10,
    S_RPT_OUT = 4'd11
  } step_e;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_CLEAR   = 4'd0,
    OP_ACCEPT  = 4'd1,
    OP_DIGIT   = 4'd2,
    OP_RED_HI  = 4'd3,
    OP_RED_LO  = 4'd4,
    OP_RD_H1   = 4'd5,
    OP_RD_H2   = 4'd6,
    OP_CAP_B   = 4'd7,
    OP_INS_WR  = 4'd8,
    OP_RD_TGT  = 4'd9,
    OP_CAP_TGT = 4'd10,
    OP_RPT_OUT = 4'd11
  } op_e;

  // Jump conditions.
  typedef enum logic [2:0] {
    CND_NEXT     = 3'd0,
    CND_JUMP     = 3'd1,
    CND_CLR_MORE = 3'd2,
    CND_DIG_MORE = 3'd3,
    CND_REPORT   = 3'd4
  } cond_e;

  // Wait conditions that hold a step.
  typedef enum logic [1:0] {
    WAIT_NONE = 2'd0,
    WAIT_IN   = 2'd1,
    WAIT_OUT  = 2'd2
  } wait_e;

  // One control word of the program.
  typedef struct packed {
    op_e   op;
    cond_e cond;
    wait_e hold;
    step_e target;
  } uword_t;

  // Sequencer to datapath.
  typedef struct packed {
    op_e  op;
    logic fire;
  } ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic in_valid;
    logic in_report;
    logic out_busy;
    logic clr_last;
    logic dig_last;
  } stat_t;

endpackage

>>> hw/rtl/two_choice_hash_bucket_balancer_top.sv
// ----------------------------------------------------------------------------
// two_choice_hash_bucket_balancer_top
// Two-choice hash bucket balancer. After reset a clearing pass writes zero to
// all 1024 bucket counters, one per cycle, and the input stays not ready
// until that pass ends. After acceptance, an insert (tuser = 0) runs eight
// radix-16 digit steps that reduce the key by 109 and by 137 in parallel, two
// steps of reduction by 2n, three steps on the single read port of the
// counter RAM and one compare-and-write step. A report (tuser = 1) runs a
// read step, a capture step and an output step. One item is in work at a
// time; the next item is accepted while the previous result still waits in
// the output register, and it holds at its write or output step until that
// result is taken.
// ----------------------------------------------------------------------------
module two_choice_hash_bucket_balancer_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [tchb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tchb_pkg::KEY_W-1:0]       cfg_data_i,
  // Request input.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tchb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // key_value[30:0]
  input  logic                             s_axis_tuser,  // mode
  // Result output.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [tchb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // bucket_index[9:0],
                                                          // bucket_length[25:10]
  output logic                             m_axis_tuser   // target_found
);

  tchb_pkg::ctrl_t ctrl;
  tchb_pkg::stat_t stat;

  // Control program.
  tchb_sequencer u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .stat_i(stat),
    .ctrl_o(ctrl)
  );

  // Datapath and ports.
  tchb_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .ctrl_i       (ctrl),
    .stat_o       (stat)
  );

endmodule

>>> hw/rtl/tchb_ram.sv
// ----------------------------------------------------------------------------
// tchb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tchb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/tchb_sequencer.sv
// ----------------------------------------------------------------------------
// tchb_sequencer
// Step counter and control store that drive the balancer datapath.
// ----------------------------------------------------------------------------
module tchb_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tchb_pkg::stat_t stat_i,
  output tchb_pkg::ctrl_t ctrl_o
);

  tchb_pkg::step_e  pc_q, pc_d;
  tchb_pkg::uword_t uw;
  logic             waiting;
  logic             take;

  // Control store: one word per step.
  always_comb begin
    unique case (pc_q)
      tchb_pkg::S_CLEAR:   uw = '{tchb_pkg::OP_CLEAR,   tchb_pkg::CND_CLR_MORE,
                                  tchb_pkg::WAIT_NONE, tchb_pkg::S_CLEAR};
      tchb_pkg::S_IDLE:    uw = '{tchb_pkg::OP_ACCEPT,  tchb_pkg::CND_REPORT,
                                  tchb_pkg::WAIT_IN,   tchb_pkg::S_RPT_RD};
      tchb_pkg::S_DIGIT:   uw = '{tchb_pkg::OP_DIGIT,   tchb_pkg::CND_DIG_MORE,
                                  tchb_pkg::WAIT_NONE, tchb_pkg::S_DIGIT};
      tchb_pkg::S_RED_HI:  uw = '{tchb_pkg::OP_RED_HI,  tchb_pkg::CND_NEXT,
                                  tchb_pkg::WAIT_NONE, tchb_pkg::S_IDLE};
      tchb_pkg::S_RED_LO:  uw = '{tchb_pkg::OP_RED_LO,  tchb_pkg::CND_NEXT,
                                  tchb_pkg::WAIT_NONE, tchb_pkg::S_IDLE};
      tchb_pkg::S_RD_H1:   uw = '{tchb_pkg::OP_RD_H1,   tchb_pkg::CND_NEXT,
                                  tchb_pkg::WAIT_NONE, tchb_pkg::S_IDLE};
      tchb_pkg::S_RD_H2:   uw = '{tchb_pkg::OP_RD_H2,   tchb_pkg::CND_NEXT,
                                  tchb_pkg::WAIT_NONE, tchb_pkg::S_IDLE};
      tchb_pkg::S_CAP_B:   uw = '{tchb_pkg::OP_CAP_B,   tchb_pkg::CND_NEXT,
                                  tchb_pkg::WAIT_NONE, tchb_pkg::S_IDLE};
      tchb_pkg::S_INS_WR:  uw = '{tchb_pkg::OP_INS_WR,  tchb_pkg::CND_JUMP,
                                  tchb_pkg::WAIT_OUT,  tchb_pkg::S_IDLE};
      tchb_pkg::S_RPT_RD:  uw = '{tchb_pkg::OP_RD_TGT,  tchb_pkg::CND_NEXT,
                                  tchb_pkg::WAIT_NONE, tchb_pkg::S_IDLE};
      tchb_pkg::S_RPT_CAP: uw = '{tchb_pkg::OP_CAP_TGT, tchb_pkg::CND_NEXT,
                                  tchb_pkg::WAIT_NONE, tchb_pkg::S_IDLE};
      tchb_pkg::S_RPT_OUT: uw = '{tchb_pkg::OP_RPT_OUT, tchb_pkg::CND_JUMP,
                                  tchb_pkg::WAIT_OUT,  tchb_pkg::S_IDLE};
      default:             uw = '{tchb_pkg::OP_ACCEPT,  tchb_pkg::CND_JUMP,
                                  tchb_pkg::WAIT_NONE, tchb_pkg::S_IDLE};
    endcase
  end

  // Wait and jump conditions of the current word.
  always_comb begin
    waiting = ((uw.hold == tchb_pkg::WAIT_IN) && !stat_i.in_valid) ||
              ((uw.hold == tchb_pkg::WAIT_OUT) && stat_i.out_busy);
    unique case (uw.cond)
      tchb_pkg::CND_NEXT:     take = 1'b0;
      tchb_pkg::CND_JUMP:     take = 1'b1;
      tchb_pkg::CND_CLR_MORE: take = !stat_i.clr_last;
      tchb_pkg::CND_DIG_MORE: take = !stat_i.dig_last;
      tchb_pkg::CND_REPORT:   take = stat_i.in_report;
      default:                take = 1'b0;
    endcase
  end

  // Next step.
  always_comb begin
    if (waiting) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = uw.target;
    end else begin
      pc_d = tchb_pkg::step_e'(pc_q + 4'd1);
    end
  end

  // Outputs to the datapath.
  always_comb begin
    ctrl_o.op   = uw.op;
    ctrl_o.fire = !waiting;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= tchb_pkg::S_CLEAR;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

>>> hw/rtl/tchb_datapath.sv
// ----------------------------------------------------------------------------
// tchb_datapath
// Hash reducers, counter RAM, target tracking and the stream ports.
// ----------------------------------------------------------------------------
module tchb_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tchb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tchb_pkg::KEY_W-1:0]          cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [tchb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [tchb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tuser,
  input  tchb_pkg::ctrl_t                     ctrl_i,
  output tchb_pkg::stat_t                     stat_o
);

  localparam int unsigned WIDE_W = tchb_pkg::REM_W + tchb_pkg::NIB_W;
  localparam int unsigned RED_W  = tchb_pkg::TOT_W + tchb_pkg::REM_W;

  // One radix-16 step of a remainder by a constant modulus.
  function automatic logic [tchb_pkg::REM_W-1:0] mod_digit(
    input logic [tchb_pkg::REM_W-1:0] r,
    input logic [tchb_pkg::NIB_W-1:0] nib,
    input int unsigned                m
  );
    logic [WIDE_W-1:0] v;
    logic [WIDE_W-1:0] res;
    v   = {r, nib};
    res = v;
    // The largest multiple that fits wins; the compares are independent.
    for (int unsigned k = 1; k < (1 << tchb_pkg::NIB_W); k++) begin
      if (v >= WIDE_W'(k * m)) begin
        res = v - WIDE_W'(k * m);
      end
    end
    return tchb_pkg::REM_W'(res);
  endfunction

  // Half of a restoring reduction by the bucket total.
  function automatic logic [tchb_pkg::REM_W-1:0] mod_total(
    input logic [tchb_pkg::REM_W-1:0] r,
    input logic [tchb_pkg::TOT_W-1:0] tot,
    input logic                       hi
  );
    logic [RED_W-1:0] v;
    logic [RED_W-1:0] d;
    v = RED_W'(r);
    for (int k = int'(tchb_pkg::REM_W) - 1; k >= 0; k--) begin
      if ((k >= tchb_pkg::HALF_STEPS) == hi) begin
        d = RED_W'(tot) << k;
        if (v >= d) begin
          v = v - d;
        end
      end
    end
    return tchb_pkg::REM_W'(v);
  endfunction

  logic [tchb_pkg::HALF_W-1:0]      half_q;
  logic [tchb_pkg::KEY_W-1:0]       tkey_q;
  logic [tchb_pkg::KEY_W-1:0]       key_q;
  logic [tchb_pkg::PAD_W-1:0]       sh_q;
  logic [tchb_pkg::REM_W-1:0]       rem_a_q, rem_b_q;
  logic [tchb_pkg::IDX_W-1:0]       cnt_q;
  logic [tchb_pkg::COUNT_WIDTH-1:0] ca_q, cb_q;
  logic [tchb_pkg::IDX_W-1:0]       tgt_idx_q;
  logic                             tgt_seen_q;
  logic                             out_valid_q;
  logic [tchb_pkg::IDX_W-1:0]       out_idx_q;
  logic [tchb_pkg::LEN_W-1:0]       out_len_q;
  logic                             out_found_q;

  logic [tchb_pkg::IDX_W-1:0]       n_eff;
  logic [tchb_pkg::TOT_W-1:0]       total;
  logic [tchb_pkg::IDX_W-1:0]       h_a, h_b, pick;
  logic                             b_less;
  logic [tchb_pkg::COUNT_WIDTH-1:0] pick_cnt, new_cnt;
  logic                             key_hit;
  logic                             fire;

  logic                             ram_we;
  logic [tchb_pkg::IDX_W-1:0]       ram_waddr, ram_raddr;
  logic [tchb_pkg::COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

  assign fire = ctrl_i.fire;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= tchb_pkg::HALF_W'(1);
      tkey_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == tchb_pkg::CFG_HALF_BUCKET_COUNT) begin
        half_q <= cfg_data_i[tchb_pkg::HALF_W-1:0];
      end else if (cfg_idx_i == tchb_pkg::CFG_TARGET_KEY) begin
        tkey_q <= cfg_data_i;
      end
    end
  end

  // Effective n: zero counts as one, large values clamp to half the table size.
  always_comb begin
    if (half_q == '0) begin
      n_eff = tchb_pkg::IDX_W'(1);
    end else if (32'(half_q) > tchb_pkg::MAX_HALF_BUCKETS) begin
      n_eff = tchb_pkg::IDX_W'(tchb_pkg::MAX_HALF_BUCKETS);
    end else begin
      n_eff = tchb_pkg::IDX_W'(half_q);
    end
    total = {n_eff, 1'b0};
  end

  // Bucket choice and saturating count update.
  always_comb begin
    h_a      = tchb_pkg::IDX_W'(rem_a_q);
    h_b      = tchb_pkg::IDX_W'(rem_b_q);
    b_less   = cb_q < ca_q;
    pick     = b_less ? h_b : h_a;
    pick_cnt = b_less ? cb_q : ca_q;
    new_cnt  = (pick_cnt == '1) ? pick_cnt : pick_cnt + 1'b1;
    key_hit  = key_q == tkey_q;
  end

  // Counter RAM access.
  always_comb begin
    ram_we    = fire && ((ctrl_i.op == tchb_pkg::OP_CLEAR) ||
                         (ctrl_i.op == tchb_pkg::OP_INS_WR));
    ram_waddr = (ctrl_i.op == tchb_pkg::OP_CLEAR) ? cnt_q : pick;
    ram_wdata = (ctrl_i.op == tchb_pkg::OP_CLEAR) ? '0 : new_cnt;
    case (ctrl_i.op)
      tchb_pkg::OP_RD_H2:  ram_raddr = h_b;
      tchb_pkg::OP_RD_TGT: ram_raddr = tgt_idx_q;
      default:             ram_raddr = h_a;
    endcase
  end

  tchb_ram #(
    .WIDTH(tchb_pkg::COUNT_WIDTH),
    .DEPTH(tchb_pkg::NUM_BUCKETS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Control state: step counter, target tracking, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      tgt_idx_q   <= '0;
      tgt_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (fire) begin
        case (ctrl_i.op)
          tchb_pkg::OP_CLEAR, tchb_pkg::OP_DIGIT: begin
            cnt_q <= cnt_q + 1'b1;
          end
          tchb_pkg::OP_ACCEPT: begin
            cnt_q <= '0;
          end
          tchb_pkg::OP_INS_WR: begin
            if (key_hit) begin
              tgt_idx_q  <= pick;
              tgt_seen_q <= 1'b1;
            end
            out_valid_q <= 1'b1;
          end
          tchb_pkg::OP_RPT_OUT: begin
            out_valid_q <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      case (ctrl_i.op)
        tchb_pkg::OP_ACCEPT: begin
          key_q   <= s_axis_tdata[tchb_pkg::KEY_W-1:0];
          sh_q    <= tchb_pkg::PAD_W'(s_axis_tdata[tchb_pkg::KEY_W-1:0]);
          rem_a_q <= '0;
          rem_b_q <= '0;
        end
        tchb_pkg::OP_DIGIT: begin
          rem_a_q <= mod_digit(rem_a_q, sh_q[tchb_pkg::PAD_W-1 -: tchb_pkg::NIB_W],
                               tchb_pkg::HASH_A);
          rem_b_q <= mod_digit(rem_b_q, sh_q[tchb_pkg::PAD_W-1 -: tchb_pkg::NIB_W],
                               tchb_pkg::HASH_B);
          sh_q    <= sh_q << tchb_pkg::NIB_W;
        end
        tchb_pkg::OP_RED_HI: begin
          rem_a_q <= mod_total(rem_a_q, total, 1'b1);
          rem_b_q <= mod_total(rem_b_q, total, 1'b1);
        end
        tchb_pkg::OP_RED_LO: begin
          rem_a_q <= mod_total(rem_a_q, total, 1'b0);
          rem_b_q <= mod_total(rem_b_q, total, 1'b0);
        end
        tchb_pkg::OP_RD_H2, tchb_pkg::OP_CAP_TGT: begin
          ca_q <= ram_rdata;
        end
        tchb_pkg::OP_CAP_B: begin
          cb_q <= ram_rdata;
        end
        tchb_pkg::OP_INS_WR: begin
          out_idx_q   <= pick;
          out_len_q   <= tchb_pkg::LEN_W'(new_cnt);
          out_found_q <= tgt_seen_q | key_hit;
        end
        tchb_pkg::OP_RPT_OUT: begin
          if (tgt_seen_q) begin
            out_idx_q   <= tgt_idx_q;
            out_len_q   <= tchb_pkg::LEN_W'(ca_q);
            out_found_q <= 1'b1;
          end else begin
            out_idx_q   <= '0;
            out_len_q   <= '0;
            out_found_q <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Stream ports.
  assign s_axis_tready = (ctrl_i.op == tchb_pkg::OP_ACCEPT);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = tchb_pkg::OUT_TDATA_W'({out_len_q, out_idx_q});
  assign m_axis_tuser  = out_found_q;

  // Status for the sequencer.
  always_comb begin
    stat_o.in_valid  = s_axis_tvalid;
    stat_o.in_report = (s_axis_tuser == tchb_pkg::MODE_REPORT);
    stat_o.out_busy  = out_valid_q;
    stat_o.clr_last  = (cnt_q == tchb_pkg::IDX_W'(tchb_pkg::NUM_BUCKETS - 1));
    stat_o.dig_last  = (cnt_q[tchb_pkg::DIG_W-1:0] == tchb_pkg::DIG_W'(tchb_pkg::DIGITS - 1));
  end

endmodule

>>> hw/rtl/tchb_checker.sv
// ----------------------------------------------------------------------------
// tchb_checker
// Port-level checks of the balancer, bound to the top level.
// ----------------------------------------------------------------------------
`include "two_choice_hash_bucket_balancer_top_macros.svh"

module tchb_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [tchb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tuser
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q, pend_d;
  logic       seen_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Requests accepted whose results are not yet taken.
  always_comb begin
    pend_d = pend_q + {1'b0, in_acc} - {1'b0, out_acc};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      seen_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (out_acc && m_axis_tuser) begin
        seen_q <= 1'b1;
      end
    end
  end

  // A stalled result holds its payload.
  `TCHB_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // At most one request in work and one result waiting.
  `TCHB_ASSERT_ALWAYS(a_pending, pend_q != 2'd3, "more than two requests outstanding")

  // Once the target has been reported as found, it stays found.
  `TCHB_ASSERT(a_found_sticky, m_axis_tvalid && seen_q |-> m_axis_tuser, "target_found dropped")

  // A found target lives in a bucket that holds at least one entry.
  `TCHB_ASSERT(a_found_len, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[25:10] != 16'd0, "found target with empty bucket")

endmodule

bind two_choice_hash_bucket_balancer_top tchb_checker u_tchb_checker (.*);
